// ----- src/sod_pkg.sv -----
// Package for the sweep object detector: field widths, reset values,
// register indexes, result codes and the result record type. No dependencies.
package sod_pkg;

  localparam int DIST_W  = 14;
  localparam int ANG_W   = 8;
  localparam int NUM_W   = 4;
  localparam int COUNT_W = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  localparam int WINDOW_LEN_DEF = 7;
  localparam int MAX_OBJECTS    = 16;

  localparam logic [DIST_W-1:0] THRESHOLD_RESET = 14'd800;
  localparam logic [ANG_W-1:0]  END_ANGLE_RESET = 8'd180;

  // Register indexes, taken from paddr[2].
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_END_ANGLE = 1'b1;

  localparam logic KIND_FILTERED = 1'b0;
  localparam logic KIND_OBJECT   = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [DIST_W-1:0] distance;
    logic [ANG_W-1:0]  angle;
    logic [NUM_W-1:0]  number;
    logic              dropped;
    logic              last;
  } result_t;

endpackage

// ----- src/sod_trim_mean.sv -----
// Trimmed mean over the sample window: sum less one minimum and one maximum,
// divided by WINDOW_LEN - 2 through a reciprocal multiply. Uses sod_pkg.
module sod_trim_mean #(
  parameter int WINDOW_LEN = sod_pkg::WINDOW_LEN_DEF
) (
  input  logic [sod_pkg::DIST_W-1:0] window [WINDOW_LEN],
  output logic [sod_pkg::DIST_W-1:0] filt
);
  import sod_pkg::*;

  localparam int SUM_W   = DIST_W + $clog2(WINDOW_LEN);
  localparam int DIV     = WINDOW_LEN - 2;
  // The shift is wide enough that the rounded-up reciprocal is exact for
  // every sum below 2**SUM_W.
  localparam int SHIFT   = SUM_W + $clog2(DIV) + 1;
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  trimmed;
  logic [DIST_W-1:0] lo;
  logic [DIST_W-1:0] hi;
  logic [PROD_W-1:0] prod;

  always_comb begin
    sum = '0;
    lo  = '1;
    hi  = '0;
    for (int k = 0; k < WINDOW_LEN; k++) begin
      sum = sum + SUM_W'(window[k]);
      if (window[k] < lo) lo = window[k];
      if (window[k] > hi) hi = window[k];
    end
    trimmed = sum - SUM_W'(lo) - SUM_W'(hi);
  end

  assign prod = PROD_W'(trimmed) * PROD_W'(RECIP);
  assign filt = prod[SHIFT +: DIST_W];

endmodule

// ----- src/sweep_object_detector.sv -----
// Top level of the sweep object detector: sample ring, object tracking,
// two-entry result buffer and APB register port. Uses sod_pkg, sod_trim_mean.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------
//   sample   | sample_valid, sample_stall | req_type, sweep_start,
//            |                            | sample_distance, sample_angle,
//            |                            | sweep_end
//   result   | result_valid, result_stall | result_kind, out_distance,
//            |                            | out_angle, object_number,
//            |                            | objects_dropped, last_result
//   config   | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// A sample is filtered in the cycle it is accepted and its first result
// appears on the next cycle from the result register. A scan reading gives
// one or two results, two when it also closes an object. sample_stall rises
// only while the result register and the second-result slot cannot take the
// next sample's results. Reset is synchronous and clears the ring, the
// tracking state and the registers to their defaults.
module sweep_object_detector #(
  parameter int WINDOW_LEN = sod_pkg::WINDOW_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  logic                        req_type,
  input  logic                        sweep_start,
  input  logic [sod_pkg::DIST_W-1:0]  sample_distance,
  input  logic [sod_pkg::ANG_W-1:0]   sample_angle,
  input  logic                        sweep_end,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic                        result_kind,
  output logic [sod_pkg::DIST_W-1:0]  out_distance,
  output logic [sod_pkg::ANG_W-1:0]   out_angle,
  output logic [sod_pkg::NUM_W-1:0]   object_number,
  output logic                        objects_dropped,
  output logic                        last_result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import sod_pkg::*;

  localparam int PTR_W = $clog2(WINDOW_LEN);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LEN - 1);

  // Configuration registers.
  logic [DIST_W-1:0] detect_threshold;
  logic [ANG_W-1:0]  sweep_end_angle;

  // Tracking state.
  logic [DIST_W-1:0]  sample_ring [WINDOW_LEN];
  logic [PTR_W-1:0]   ring_pointer;
  logic               inside_object;
  logic [ANG_W-1:0]   entry_angle;
  logic [DIST_W-1:0]  entry_distance;
  logic [COUNT_W-1:0] object_count;

  // Result buffer.
  result_t res_out;
  result_t res_pend;
  logic    out_full;
  logic    pend_full;

  logic cfg_write;
  logic accept;
  logic out_taken;

  logic [PTR_W-1:0]   wp;
  logic [DIST_W-1:0]  window [WINDOW_LEN];
  logic [DIST_W-1:0]  filt;
  logic               inside_eff;
  logic [COUNT_W-1:0] count_eff;
  logic               below;
  logic               enter;
  logic               close_leave;
  logic               close_end;
  logic               closing;
  logic               dropped;
  logic [ANG_W-1:0]   ent_ang_eff;
  logic [DIST_W-1:0]  ent_dist_eff;
  logic [DIST_W:0]    dist_sum;
  logic [ANG_W:0]     ang_sum;
  logic [DIST_W-1:0]  obj_dist;
  logic [ANG_W-1:0]   obj_ang;
  result_t            res_filt;
  result_t            res_obj;

  // ---------------------------------------------------------------- APB port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = 32'(detect_threshold);
      REG_END_ANGLE: prdata = 32'(sweep_end_angle);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_threshold <= THRESHOLD_RESET;
      sweep_end_angle  <= END_ANGLE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_THRESHOLD: detect_threshold <= pwdata[DIST_W-1:0];
        REG_END_ANGLE: sweep_end_angle  <= pwdata[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------- handshake
  assign out_taken    = out_full && !result_stall;
  assign sample_stall = pend_full || (out_full && result_stall);
  assign accept       = sample_valid && !sample_stall;

  // ----------------------------------------------------------------- filter
  // A sweep start rewinds the ring before this reading is written.
  assign wp         = sweep_start ? '0 : ring_pointer;
  assign inside_eff = sweep_start ? 1'b0 : inside_object;
  assign count_eff  = sweep_start ? '0 : object_count;

  always_comb begin
    for (int k = 0; k < WINDOW_LEN; k++) begin
      window[k] = (PTR_W'(k) == wp) ? sample_distance : sample_ring[k];
    end
  end

  sod_trim_mean #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_trim_mean (
    .window(window),
    .filt  (filt)
  );

  // ---------------------------------------------------------- object tracking
  assign below       = filt < detect_threshold;
  assign enter       = below && !inside_eff;
  assign close_leave = !below && inside_eff;
  // An object open on the last reading (also one just entered) closes here.
  assign close_end   = sweep_end && below;
  assign closing     = close_leave || close_end;
  assign dropped     = 32'(count_eff) >= MAX_OBJECTS;

  assign ent_ang_eff  = enter ? sample_angle : entry_angle;
  assign ent_dist_eff = enter ? filt : entry_distance;

  always_comb begin
    if (close_leave) begin
      dist_sum = {1'b0, entry_distance} + {1'b0, filt};
      ang_sum  = {1'b0, entry_angle} + {1'b0, sample_angle};
      obj_dist = dist_sum[DIST_W:1];
    end else begin
      dist_sum = '0;
      ang_sum  = {1'b0, ent_ang_eff} + {1'b0, sweep_end_angle};
      obj_dist = ent_dist_eff;
    end
    obj_ang = ang_sum[ANG_W:1];
  end

  always_comb begin
    res_filt.kind     = KIND_FILTERED;
    res_filt.distance = filt;
    res_filt.angle    = sample_angle;
    res_filt.number   = '0;
    res_filt.dropped  = 1'b0;
    res_filt.last     = !closing;

    res_obj.kind      = KIND_OBJECT;
    res_obj.distance  = dropped ? '0 : obj_dist;
    res_obj.angle     = dropped ? '0 : obj_ang;
    res_obj.number    = dropped ? '0 : count_eff[NUM_W-1:0];
    res_obj.dropped   = dropped;
    res_obj.last      = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
        sample_ring[k] <= '0;
      end
      ring_pointer   <= '0;
      inside_object  <= 1'b0;
      entry_angle    <= '0;
      entry_distance <= '0;
      object_count   <= '0;
    end else if (accept) begin
      sample_ring[wp] <= sample_distance;
      ring_pointer    <= (wp == PTR_LAST) ? '0 : wp + 1'b1;
      if (req_type) begin
        inside_object <= below && !close_end;
        if (enter) begin
          entry_angle    <= sample_angle;
          entry_distance <= filt;
        end
        if (closing && count_eff != COUNT_MAX) begin
          object_count <= count_eff + 1'b1;
        end else begin
          object_count <= count_eff;
        end
      end else begin
        inside_object <= inside_eff;
        object_count  <= count_eff;
      end
    end
  end

  // ---------------------------------------------------------- result buffer
  // The second result of a reading waits in the pending slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      pend_full <= 1'b0;
    end else if (accept && req_type) begin
      out_full  <= 1'b1;
      pend_full <= closing;
    end else if (out_taken) begin
      out_full  <= pend_full;
      pend_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req_type) begin
      res_out  <= res_filt;
      res_pend <= res_obj;
    end else if (out_taken && pend_full) begin
      res_out <= res_pend;
    end
  end

  assign result_valid    = out_full;
  assign result_kind     = res_out.kind;
  assign out_distance    = res_out.distance;
  assign out_angle       = res_out.angle;
  assign object_number   = res_out.number;
  assign objects_dropped = res_out.dropped;
  assign last_result     = res_out.last;

endmodule

// ----- tb/sod_checker.sv -----
// Checker for sweep_object_detector: follows the sample, result and register
// transfers, predicts every result record and compares it field by field.
// Depends on sod_pkg for widths, register indexes, result codes and result_t.
module sod_checker #(
  parameter int WINDOW_LEN = sod_pkg::WINDOW_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  input  logic                       sample_stall,
  input  logic                       req_type,
  input  logic                       sweep_start,
  input  logic [sod_pkg::DIST_W-1:0] sample_distance,
  input  logic [sod_pkg::ANG_W-1:0]  sample_angle,
  input  logic                       sweep_end,
  input  logic                       result_valid,
  input  logic                       result_stall,
  input  logic                       result_kind,
  input  logic [sod_pkg::DIST_W-1:0] out_distance,
  input  logic [sod_pkg::ANG_W-1:0]  out_angle,
  input  logic [sod_pkg::NUM_W-1:0]  object_number,
  input  logic                       objects_dropped,
  input  logic                       last_result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  output int                         fail_count,
  output int                         pending_count
);
  import sod_pkg::*;

  logic [DIST_W-1:0]  ring [WINDOW_LEN];
  int unsigned        ring_ptr;
  logic               in_object;
  logic [ANG_W-1:0]   entry_ang;
  logic [DIST_W-1:0]  entry_dist;
  logic [COUNT_W-1:0] obj_count;
  logic [DIST_W-1:0]  threshold;
  logic [ANG_W-1:0]   end_angle;

  // Records predicted for accepted samples, oldest first.
  result_t expected_records[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  function automatic logic [DIST_W-1:0] trimmed_mean();
    int unsigned sum;
    int unsigned lo;
    int unsigned hi;
    int          k;
    sum = 0;
    lo  = 2**DIST_W - 1;
    hi  = 0;
    for (k = 0; k < WINDOW_LEN; k++) begin
      sum += ring[k];
      if (ring[k] < lo) lo = ring[k];
      if (ring[k] > hi) hi = ring[k];
    end
    return DIST_W'((sum - lo - hi) / (WINDOW_LEN - 2));
  endfunction

  // Builds an object record and updates the object count; past the limit
  // the record carries only the dropped flag.
  function automatic result_t close_object(logic [DIST_W-1:0] obj_dist,
                                           logic [ANG_W-1:0] obj_ang);
    result_t rec;
    rec      = '0;
    rec.kind = KIND_OBJECT;
    if (obj_count >= MAX_OBJECTS) begin
      rec.dropped = 1'b1;
    end else begin
      rec.distance = obj_dist;
      rec.angle    = obj_ang;
      rec.number   = obj_count[NUM_W-1:0];
    end
    if (obj_count < COUNT_MAX) obj_count++;
    in_object = 1'b0;
    return rec;
  endfunction

  task automatic track_reading();
    logic [DIST_W-1:0] filt;
    logic [DIST_W:0]   dist_sum;
    logic [ANG_W:0]    ang_sum;
    result_t           batch [3];
    int                n;
    int                i;
    n = 0;
    if (sweep_start) begin
      ring_ptr  = 0;
      in_object = 1'b0;
      obj_count = '0;
    end
    ring[ring_ptr] = sample_distance;
    ring_ptr       = (ring_ptr + 1) % WINDOW_LEN;
    if (req_type) begin
      filt              = trimmed_mean();
      batch[n]          = '0;
      batch[n].kind     = KIND_FILTERED;
      batch[n].distance = filt;
      batch[n].angle    = sample_angle;
      n++;
      if (filt < threshold) begin
        if (!in_object) begin
          in_object  = 1'b1;
          entry_ang  = sample_angle;
          entry_dist = filt;
        end
      end else if (in_object) begin
        dist_sum = {1'b0, entry_dist} + {1'b0, filt};
        ang_sum  = {1'b0, entry_ang} + {1'b0, sample_angle};
        batch[n] = close_object(dist_sum[DIST_W:1], ang_sum[ANG_W:1]);
        n++;
      end
      // An object still open on the last reading closes midway between entry and end angle.
      if (sweep_end && in_object) begin
        ang_sum  = {1'b0, entry_ang} + {1'b0, end_angle};
        batch[n] = close_object(entry_dist, ang_sum[ANG_W:1]);
        n++;
      end
      batch[n-1].last = 1'b1;
      for (i = 0; i < n; i++) expected_records.push_back(batch[i]);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    int      k;
    if (rst) begin
      for (k = 0; k < WINDOW_LEN; k++) ring[k] = '0;
      ring_ptr   = 0;
      in_object  = 1'b0;
      entry_ang  = '0;
      entry_dist = '0;
      obj_count  = '0;
      threshold  = THRESHOLD_RESET;
      end_angle  = END_ANGLE_RESET;
      expected_records.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_THRESHOLD: threshold = pwdata[DIST_W-1:0];
          REG_END_ANGLE: end_angle = pwdata[ANG_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_records.size() == 0) begin
          $error("result transfer with no prediction waiting: kind %0d distance %0d",
                 result_kind, out_distance);
          fail_count++;
        end else begin
          want = expected_records.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(result_kind));
          check_field("out_distance", 32'(want.distance), 32'(out_distance));
          check_field("out_angle", 32'(want.angle), 32'(out_angle));
          check_field("object_number", 32'(want.number), 32'(object_number));
          check_field("objects_dropped", 32'(want.dropped), 32'(objects_dropped));
          check_field("last_result", 32'(want.last), 32'(last_result));
        end
      end
      if (sample_valid && !sample_stall) track_reading();
    end
    pending_count = expected_records.size();
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top for sweep_object_detector: clock, reset, sample and register
// stimulus, random result stall, and the verdict. Uses sod_pkg and sod_checker.
module tb;
  import sod_pkg::*;

  localparam int ITEM_TARGET   = 1350;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 4;

  logic              clk = 1'b0;
  logic              rst;
  logic              sample_valid;
  logic              sample_stall;
  logic              req_type;
  logic              sweep_start;
  logic [DIST_W-1:0] sample_distance;
  logic [ANG_W-1:0]  sample_angle;
  logic              sweep_end;
  logic              result_valid;
  logic              result_stall;
  logic              result_kind;
  logic [DIST_W-1:0] out_distance;
  logic [ANG_W-1:0]  out_angle;
  logic [NUM_W-1:0]  object_number;
  logic              objects_dropped;
  logic              last_result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int items_sent  = 0;
  int cur_thr     = THRESHOLD_RESET;
  int cur_angle   = END_ANGLE_RESET;
  bit quiet       = 1'b0;

  sweep_object_detector i_dut (.*);

  sod_checker i_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, none at all during quiet stretches.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int hold;
    hold         = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        result_stall = 1'b1;
        hold--;
      end else begin
        result_stall = 1'b0;
        hold         = pick_gap();
      end
    end
  end

  task automatic idle_sender(int n);
    if (n > 0) begin
      @(negedge clk);
      sample_valid    = 1'b0;
      sample_distance = DIST_W'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_sample(bit scan, bit start, int dist_val, int ang, bit last);
    @(negedge clk);
    sample_valid    = 1'b1;
    req_type        = scan;
    sweep_start     = start;
    sample_distance = dist_val[DIST_W-1:0];
    sample_angle    = ang[ANG_W-1:0];
    sweep_end       = last;
    do @(posedge clk); while (sample_stall);
    items_sent++;
    idle_sender(pick_gap());
  endtask

  task automatic drain_results();
    @(negedge clk);
    sample_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Upper data bits are random; only the register's own width may count.
  task automatic configure(int thr, int ang);
    drain_results();
    write_reg(REG_THRESHOLD, ($urandom & ~32'h3FFF) | thr);
    write_reg(REG_END_ANGLE, ($urandom & ~32'hFF) | ang);
    cur_thr   = thr;
    cur_angle = ang;
  endtask

  function automatic int pick_threshold();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 2**DIST_W - 1;
      2:       return $urandom_range(1, 2**DIST_W - 2);
      default: return $urandom_range(600, 6000);
    endcase
  endfunction

  function automatic int pick_end_angle();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 2**ANG_W - 1;
      default: return $urandom_range(0, 2**ANG_W - 1);
    endcase
  endfunction

  // One sweep: start, primes to fill the ring, then scans alternating between
  // runs of near and far readings. A broken sweep skips parts of that.
  task automatic run_sweep();
    int n_prime;
    int n_scan;
    int total;
    int ang;
    int step;
    int run_left;
    int near_hi;
    int far_lo;
    int d;
    int i;
    bit near;
    bit broken;
    bit start;
    bit last;
    broken   = ($urandom_range(0, 9) == 0);
    n_prime  = broken ? $urandom_range(0, 6) : 6;
    n_scan   = $urandom_range(5, 40);
    total    = n_prime + n_scan;
    ang      = $urandom_range(0, 30);
    step     = $urandom_range(1, 6);
    near_hi  = cur_thr * 3 / 4;
    far_lo   = cur_thr + (2**DIST_W - 1 - cur_thr) / 4;
    near     = 1'b0;
    run_left = $urandom_range(3, 12);
    for (i = 0; i < total; i++) begin
      if (run_left == 0) begin
        near     = !near;
        run_left = $urandom_range(3, 12);
      end
      run_left--;
      if ($urandom_range(0, 19) == 0) d = $urandom_range(0, 2**DIST_W - 1);
      else if (near) d = $urandom_range(0, near_hi);
      else d = $urandom_range(far_lo, 2**DIST_W - 1);
      if (broken) begin
        start = (i == 0) && $urandom_range(0, 1);
        last  = ($urandom_range(0, 7) == 0);
        ang   = $urandom_range(0, 2**ANG_W - 1);
      end else begin
        start = (i == 0);
        last  = (i == total - 1);
        ang   = (ang + step) % 2**ANG_W;
      end
      send_sample(i >= n_prime, start, d, ang, last);
    end
  endtask

  // Near scans, each with sweep_end, that open and close objects, to run past
  // the object limit and the saturation of the count.
  task automatic run_storm();
    int i;
    if (cur_thr < 400) configure(800, cur_angle);
    for (i = 0; i < 40; i++)
      send_sample(1'b1, i == 0, $urandom_range(0, 300), $urandom_range(0, 255), 1'b1);
  endtask

  task automatic run_noise();
    repeat ($urandom_range(10, 30))
      send_sample($urandom_range(0, 1), ($urandom_range(0, 7) == 0),
                  $urandom_range(0, 2**DIST_W - 1), $urandom_range(0, 2**ANG_W - 1),
                  ($urandom_range(0, 7) == 0));
  endtask

  initial begin
    int i;
    rst             = 1'b1;
    sample_valid    = 1'b0;
    req_type        = 1'b0;
    sweep_start     = 1'b0;
    sample_distance = '0;
    sample_angle    = '0;
    sweep_end       = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed part, with the reset register values first. Primes fill all but one
    // ring slot with the largest distance; one of them carries sweep_end.
    send_sample(1'b0, 1'b1, 2**DIST_W - 1, 255, 1'b0);
    for (i = 0; i < 5; i++) send_sample(1'b0, 1'b0, 2**DIST_W - 1, 5 * i, i == 2);
    // This scan wraps the ring pointer.
    send_sample(1'b1, 1'b0, 2**DIST_W - 1, 0, 1'b0);
    // Zero readings pull the trimmed mean down until an object opens.
    for (i = 1; i <= 6; i++) send_sample(1'b1, 1'b0, 0, 10 * i, 1'b0);
    // A prime reading with sweep_end leaves the object open.
    send_sample(1'b0, 1'b0, 0, 70, 1'b1);
    // The open object closes on the last scan, midway between entry and end angle.
    send_sample(1'b1, 1'b0, 2**DIST_W - 1, 100, 1'b1);
    // An object that opens on the last reading closes on it as well.
    send_sample(1'b1, 1'b1, 0, 200, 1'b1);
    configure(2**DIST_W - 1, 2**ANG_W - 1);
    for (i = 0; i < 7; i++) send_sample(1'b1, 1'b0, 2**DIST_W - 1, 255 - i, 1'b0);
    configure(0, 0);
    send_sample(1'b1, 1'b1, 0, 0, 1'b1);

    // Random part.
    configure(800, 180);
    run_storm();
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) configure(pick_threshold(), pick_end_angle());
      quiet = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 24) == 0) run_storm();
      else if ($urandom_range(0, 9) == 0) run_noise();
      else run_sweep();
      if ($urandom_range(0, 7) == 0) drain_results();
    end
    quiet = 1'b0;
    drain_results();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sweep_object_detector.f -----
src/sod_pkg.sv
src/sod_trim_mean.sv
src/sweep_object_detector.sv
tb/sod_checker.sv
tb/tb.sv
